@@ hw/rtl/srmq_pkg.sv @@
// Shared types, codes and a helper function for the sparse-table range-minimum engine.
// No dependencies; imported by sparse_table_range_minimum, range_min_checker and testbench.
package srmq_pkg;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned POS_W  = 10;
    localparam int unsigned ELEM_W = 32;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned CFG_W  = 11;
    localparam int unsigned LONE_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_BUILT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RESP   = 4'b0010,
        S_BRD    = 4'b0100,
        S_BDRAIN = 4'b1000
    } t_state;

    // Position of the highest set bit of a range length (length is at least one).
    function automatic logic [LONE_W-1:0] leading_one(input logic [POS_W:0] x);
        logic [LONE_W-1:0] k;
        k = '0;
        for (int b = 1; b <= POS_W; b++) begin
            if (x[b]) begin
                k = LONE_W'(b);
            end
        end
        return k;
    endfunction

endpackage

@@ hw/rtl/sparse_table_range_minimum.sv @@
// Sparse-table range-minimum engine: level memory, build sequencer and query path.
// Depends on srmq_pkg.
//
// Channel   Dir  Handshake                  Payload
// config    in   i_cfg_we                   i_cfg_wdata (array_length)
// items     in   i_in_valid / o_in_ready    i_command, i_position, i_other_end, i_element_value
// results   out  o_out_valid / i_out_ready  o_minimum, o_status
//
// Write, query, unknown: accept (a valid write or query accesses memory), then result from response state.
// A build over length N fills levels j = 1..floor(log2 N), one level after another;
// each entry needs one pass through the two read ports of the level memory.
// Reset is synchronous; the level memory is not cleared and holds garbage until written.
// One result waits in the output register; a new item is accepted meanwhile, and its
// result holds in the response state until the output register frees up.
module sparse_table_range_minimum
    import srmq_pkg::*;
#(
    parameter int unsigned DEPTH       = 1024,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [POS_W-1:0]       i_position,
    input  logic [POS_W-1:0]       i_other_end,
    input  logic [ELEM_W-1:0]      i_element_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0] o_minimum,
    output logic [ST_W-1:0]        o_status
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned LVLS  = $clog2(DEPTH + 1);
    localparam int unsigned LVL_W = $clog2(LVLS);
    localparam int unsigned AW    = LVL_W + IDX_W;
    localparam int unsigned MEM_N = LVLS << IDX_W;
    localparam int unsigned LEN_W = $clog2(DEPTH + 1);
    localparam int unsigned EW    = (VALUE_WIDTH > ELEM_W) ? VALUE_WIDTH : ELEM_W;

    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_tbl_ready, n_tbl_ready;
    logic [LVL_W-1:0]       r_lvl, n_lvl;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_bw_valid, n_bw_valid;
    logic [AW-1:0]          r_bw_addr, n_bw_addr;
    logic                   r_res_mem, n_res_mem;
    logic [ST_W-1:0]        r_res_st, n_res_st;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_minimum, n_minimum;
    logic [ST_W-1:0]        r_status, n_status;

    logic [VALUE_WIDTH-1:0] mem [MEM_N];
    logic [VALUE_WIDTH-1:0] r_rd0, r_rd1;

    logic                   w_accept;
    logic [31:0]            w_pos32, w_oth32, w_len32, w_cfg32, w_nlvl32;
    logic [EW-1:0]          w_elem_ext;
    logic [VALUE_WIDTH-1:0] w_elem, w_min;
    logic [ST_W-1:0]        w_q_st;
    logic [POS_W-1:0]       w_lo, w_hi;
    logic [POS_W:0]         w_span, w_r0;
    logic [LONE_W-1:0]      w_k;
    logic [LVL_W-1:0]       w_blvl;
    logic                   w_bcont, w_bnext;
    logic                   w_load;
    logic                   w_we, w_re;
    logic [AW-1:0]          w_waddr, w_raddr0, w_raddr1;
    logic [VALUE_WIDTH-1:0] w_wdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_pos32    = 32'(i_position);
    assign w_oth32    = 32'(i_other_end);
    assign w_len32    = 32'(r_len);
    assign w_cfg32    = 32'(i_cfg_wdata);
    assign w_elem_ext = EW'(i_element_value);
    assign w_elem     = w_elem_ext[VALUE_WIDTH-1:0];
    assign w_min      = (r_rd0 < r_rd1) ? r_rd0 : r_rd1;

    // Query status and address path: order the endpoints, find the window level, locate the right window.
    always_comb begin
        if (!r_tbl_ready) begin
            w_q_st = ST_NOT_BUILT;
        end else if (w_pos32 >= w_len32 || w_oth32 >= w_len32) begin
            w_q_st = ST_RANGE;
        end else begin
            w_q_st = ST_OK;
        end
        w_lo   = (i_position < i_other_end) ? i_position : i_other_end;
        w_hi   = (i_position < i_other_end) ? i_other_end : i_position;
        w_span = ({1'b0, w_hi} - {1'b0, w_lo}) + (POS_W+1)'(1);
        w_k    = leading_one(w_span);
        w_r0   = ({1'b0, w_hi} + (POS_W+1)'(1)) - ((POS_W+1)'(1) << w_k);
    end

    // Build sequencing: entry (j, i) exists while i + 2^j fits inside the length.
    assign w_blvl   = r_lvl - LVL_W'(1);
    assign w_bcont  = (32'(r_idx) + 32'd1 + (32'd1 << r_lvl)) <= w_len32;
    assign w_nlvl32 = 32'(r_lvl) + 32'd1;
    assign w_bnext  = (w_nlvl32 < LVLS) && ((32'd1 << w_nlvl32) <= w_len32);

    // Memory port control.
    always_comb begin
        w_re     = 1'b0;
        w_raddr0 = {w_blvl, r_idx};
        w_raddr1 = {w_blvl, IDX_W'(32'(r_idx) + (32'd1 << w_blvl))};
        if (r_state == S_BRD) begin
            w_re = 1'b1;
        end else if (w_accept && i_command == CMD_QUERY && w_q_st == ST_OK) begin
            w_re     = 1'b1;
            w_raddr0 = {LVL_W'(w_k), IDX_W'(32'(w_lo))};
            w_raddr1 = {LVL_W'(w_k), IDX_W'(32'(w_r0))};
        end

        w_we    = 1'b0;
        w_waddr = r_bw_addr;
        w_wdata = w_min;
        if (r_bw_valid) begin
            w_we = 1'b1;
        end else if (w_accept && i_command == CMD_WRITE && w_pos32 < DEPTH) begin
            w_we    = 1'b1;
            w_waddr = {{LVL_W{1'b0}}, IDX_W'(w_pos32)};
            w_wdata = w_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd0 <= mem[w_raddr0];
            r_rd1 <= mem[w_raddr1];
        end
    end

    assign w_load = (r_state == S_RESP) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_tbl_ready = r_tbl_ready;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_bw_valid  = 1'b0;
        n_bw_addr   = r_bw_addr;
        n_res_mem   = r_res_mem;
        n_res_st    = r_res_st;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_mem = 1'b0;
                    n_res_st  = ST_OK;
                    n_state   = S_RESP;
                    unique case (t_cmd'(i_command))
                        CMD_WRITE: begin
                            n_tbl_ready = 1'b0;
                        end
                        CMD_BUILD: begin
                            if (w_len32 >= 32'd2) begin
                                n_lvl   = LVL_W'(1);
                                n_idx   = '0;
                                n_state = S_BRD;
                            end else begin
                                n_tbl_ready = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            n_res_mem = (w_q_st == ST_OK);
                            n_res_st  = w_q_st;
                        end
                        CMD_NONE: begin
                        end
                    endcase
                end
            end
            S_BRD: begin
                // Reads for entry i go out now; its minimum is written next cycle.
                n_bw_valid = 1'b1;
                n_bw_addr  = {r_lvl, r_idx};
                if (w_bcont) begin
                    n_idx = r_idx + IDX_W'(1);
                end else begin
                    n_state = S_BDRAIN;
                end
            end
            S_BDRAIN: begin
                // The level's last entry is written here, before the next level reads it.
                if (w_bnext) begin
                    n_lvl   = LVL_W'(w_nlvl32);
                    n_idx   = '0;
                    n_state = S_BRD;
                end else begin
                    n_tbl_ready = 1'b1;
                    n_state     = S_RESP;
                end
            end
            S_RESP: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_tbl_ready = 1'b0;
            if (w_cfg32 == 32'd0) begin
                n_len = LEN_W'(1);
            end else if (w_cfg32 > DEPTH) begin
                n_len = LEN_W'(DEPTH);
            end else begin
                n_len = LEN_W'(w_cfg32);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_minimum   = r_minimum;
        n_status    = r_status;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_minimum   = r_res_mem ? w_min : '0;
            n_status    = r_res_st;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_W'(1);
            r_tbl_ready <= 1'b0;
            r_lvl       <= '0;
            r_idx       <= '0;
            r_bw_valid  <= 1'b0;
            r_res_mem   <= 1'b0;
            r_res_st    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_tbl_ready <= n_tbl_ready;
            r_lvl       <= n_lvl;
            r_idx       <= n_idx;
            r_bw_valid  <= n_bw_valid;
            r_res_mem   <= n_res_mem;
            r_res_st    <= n_res_st;
            r_out_valid <= n_out_valid;
        end
        r_bw_addr <= n_bw_addr;
        r_minimum <= n_minimum;
        r_status  <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_minimum   = r_minimum;
    assign o_status    = r_status;

    // One item at a time: nothing is accepted in the cycle after an accept.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("item accepted while the previous one is in flight");

    // Build writes never land on level zero.
    a_bw_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bw_valid |-> (r_bw_addr[AW-1:IDX_W] != '0))
        else $error("build write aimed at level zero");

    // A pending build write only exists inside the build sequence.
    a_bw_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bw_valid |-> (r_state == S_BRD || r_state == S_BDRAIN))
        else $error("build write outside the build sequence");

    // An element write invalidates the table.
    a_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_WRITE) |=> !r_tbl_ready)
        else $error("table still marked built after an element write");

    // A successful query result comes from the memory read.
    a_query_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_QUERY && w_q_st == ST_OK) |=> (r_res_mem && $past(w_re)))
        else $error("query result not sourced from the level memory");

endmodule

@@ verif/range_min_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the sparse-table range-minimum engine: tracks the level store,
// predicts one answer per accepted item and compares it with the result channel.
// Depends on srmq_pkg.
module range_min_checker
    import srmq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [POS_W-1:0]  i_position,
    input  logic [POS_W-1:0]  i_other_end,
    input  logic [ELEM_W-1:0] i_element_value,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [ELEM_W-1:0] i_minimum,
    input  logic [ST_W-1:0]   i_status,
    output int                o_pending,
    output int                o_mismatches
);

    localparam int unsigned DEPTH     = 1024;
    localparam int unsigned TOP_LEVEL = 10;

    typedef struct packed {
        logic [ELEM_W-1:0] minimum;
        logic [ST_W-1:0]   status;
    } t_answer;

    logic [ELEM_W-1:0] level_mem [0:TOP_LEVEL][0:DEPTH-1];
    logic [CFG_W-1:0]  span_len = 1;
    bit                levels_valid;
    t_answer           answers_due [$];
    int                mismatch_count;

    function automatic logic [ELEM_W-1:0] lesser(input logic [ELEM_W-1:0] x,
                                                 input logic [ELEM_W-1:0] y);
        return (x < y) ? x : y;
    endfunction

    // Level j holds the minimum of every window of 2^j elements inside the length.
    function automatic void rebuild_levels();
        int unsigned j;
        int unsigned i;
        int unsigned half;
        for (j = 1; j <= TOP_LEVEL && (1 << j) <= span_len; j++) begin
            half = 1 << (j - 1);
            for (i = 0; i + 2 * half <= span_len; i++) begin
                level_mem[j][i] = lesser(level_mem[j-1][i], level_mem[j-1][i+half]);
            end
        end
        levels_valid = 1'b1;
    endfunction

    function automatic t_answer answer_for(input t_cmd cmd, input logic [POS_W-1:0] a,
                                           input logic [POS_W-1:0] b,
                                           input logic [ELEM_W-1:0] val);
        t_answer     ans;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        int unsigned r0;
        ans.minimum = '0;
        ans.status  = ST_OK;
        case (cmd)
            CMD_WRITE: begin
                level_mem[0][a] = val;
                levels_valid = 1'b0;
            end
            CMD_BUILD: rebuild_levels();
            CMD_QUERY: begin
                // The not-built check takes precedence over the range check.
                if (!levels_valid) begin
                    ans.status = ST_NOT_BUILT;
                end else if (a >= span_len || b >= span_len) begin
                    ans.status = ST_RANGE;
                end else begin
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                    k = 0;
                    while (((hi - lo + 1) >> (k + 1)) != 0) begin
                        k++;
                    end
                    r0 = hi + 1 - (1 << k);
                    ans.minimum = lesser(level_mem[k][lo], level_mem[k][r0]);
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer due;
        t_answer got;
        if (!i_rst_n) begin
            answers_due.delete();
            levels_valid = 1'b0;
            span_len = 1;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.minimum = i_minimum;
                got.status  = i_status;
                if (answers_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, minimum %h status %0d",
                             $time, got.minimum, got.status);
                end else begin
                    due = answers_due.pop_front();
                    if (got.minimum !== due.minimum) begin
                        mismatch_count++;
                        $display("%0t: minimum expected %h, got %h",
                                 $time, due.minimum, got.minimum);
                    end
                    if (got.status !== due.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, due.status, got.status);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_wdata == 0) begin
                    span_len = 1;
                end else if (i_cfg_wdata > DEPTH) begin
                    span_len = CFG_W'(DEPTH);
                end else begin
                    span_len = i_cfg_wdata;
                end
                levels_valid = 1'b0;
            end
            if (i_in_valid && i_in_ready) begin
                answers_due = {answers_due, answer_for(t_cmd'(i_command), i_position,
                                                       i_other_end, i_element_value)};
            end
        end
        o_pending    <= answers_due.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Top of the range-minimum testbench: clock, reset, item and length stimulus, verdict.
// Depends on srmq_pkg, sparse_table_range_minimum and range_min_checker.
module testbench;
    import srmq_pkg::*;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned RST_CYCLES  = 9;
    localparam int unsigned DEPTH       = 1024;
    localparam int unsigned ITEM_TARGET = 1750;
    localparam int unsigned PACE_SPAN   = 64;
    localparam int unsigned CYCLE_LIMIT = 4000000;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_SINK_STALLS,
        PACE_BOTH
    } t_pace;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [CMD_W-1:0]  command = '0;
    logic [POS_W-1:0]  position = '0;
    logic [POS_W-1:0]  other_end = '0;
    logic [ELEM_W-1:0] element_value = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ELEM_W-1:0] minimum;
    logic [ST_W-1:0]   status;

    t_pace       pace = PACE_FULL;
    int          pending;
    int          mismatches;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned cur_len = 1;
    bit          loaded [0:DEPTH-1];

    sparse_table_range_minimum u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (command),
        .i_position      (position),
        .i_other_end     (other_end),
        .i_element_value (element_value),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_minimum       (minimum),
        .o_status        (status)
    );

    range_min_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_command       (command),
        .i_position      (position),
        .i_other_end     (other_end),
        .i_element_value (element_value),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_minimum       (minimum),
        .i_status        (status),
        .o_pending       (pending),
        .o_mismatches    (mismatches)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk) begin
        case (pace)
            PACE_SINK_STALLS: out_ready <= ($urandom_range(99) >= 70);
            PACE_BOTH:        out_ready <= ($urandom_range(99) >= 30);
            default:          out_ready <= 1'b1;
        endcase
    end

    // Called right after the clock rises; returns right after the engine accepts the item.
    task automatic send_item(input t_cmd cmd, input logic [POS_W-1:0] pos,
                             input logic [POS_W-1:0] oth, input logic [ELEM_W-1:0] val);
        int unsigned gap_pct;
        if (items_sent % PACE_SPAN == 0) begin
            pace <= t_pace'((items_sent / PACE_SPAN) % 4);
        end
        gap_pct = (pace == PACE_SEND_GAPS) ? 70 : (pace == PACE_BOTH) ? 30 : 0;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        position      <= pos;
        other_end     <= oth;
        element_value <= val;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_length(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_len = (value == 0) ? 1 : (value > DEPTH) ? DEPTH : value;
    endtask

    // Mixes extremes and a narrow band so that ties between windows are common.
    function automatic logic [ELEM_W-1:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) return '0;
        if (pick < 10) return '1;
        if (pick < 35) return ELEM_W'($urandom_range(15));
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_index();
        return POS_W'($urandom_range(cur_len - 1));
    endfunction

    task automatic write_elem(input logic [POS_W-1:0] pos, input logic [ELEM_W-1:0] val);
        send_item(CMD_WRITE, pos, POS_W'($urandom), val);
        loaded[pos] = 1'b1;
    endtask

    task automatic build();
        send_item(CMD_BUILD, POS_W'($urandom), POS_W'($urandom), $urandom);
    endtask

    task automatic ask(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
        send_item(CMD_QUERY, a, b, $urandom);
    endtask

    // A build must never read an element that was never written.
    task automatic fill_loaded();
        for (int i = 0; i < cur_len; i++) begin
            if (!loaded[i]) write_elem(POS_W'(i), rand_value());
        end
    endtask

    task automatic send_query();
        int unsigned      pick;
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
        pick = $urandom_range(99);
        a = pick_index();
        b = pick_index();
        if (pick < 12) begin
            a = '0;
            b = POS_W'(cur_len - 1);
        end else if (pick < 24) begin
            b = a;
        end
        if ($urandom_range(1)) ask(b, a);
        else ask(a, b);
    endtask

    task automatic send_stray_query();
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
        if (cur_len >= DEPTH) begin
            send_query();
        end else begin
            a = POS_W'($urandom_range(DEPTH - 1, cur_len));
            b = ($urandom_range(3) == 0) ? POS_W'($urandom_range(DEPTH - 1, cur_len))
                                         : pick_index();
            if ($urandom_range(1)) ask(b, a);
            else ask(a, b);
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned ops;
        int unsigned pick;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset length of one.
        ask(10'd0, 10'd0);
        send_item(CMD_NONE, '1, '1, '1);
        write_elem(10'd0, '1);
        write_elem(10'd1023, '0);
        ask(10'd0, 10'd0);
        build();
        ask(10'd0, 10'd0);
        ask(10'd0, 10'd1);
        ask(10'd1023, 10'd0);
        write_elem(10'd1, '0);
        // Out of range and not built at once: not built wins.
        ask(10'd1023, 10'd1023);
        set_length(CFG_W'(4));
        write_elem(10'd2, 32'h8000_0000);
        write_elem(10'd3, 32'h0000_0001);
        build();
        ask(10'd3, 10'd0);
        ask(10'd2, 10'd3);
        ask(10'd0, 10'd0);
        ask(10'd3, 10'd3);
        ask(10'd2, 10'd1);
        ask(10'd4, 10'd0);
        ask(10'd0, 10'd4);

        phase = 0;
        while (items_sent < ITEM_TARGET || phase < 7) begin
            case (phase)
                2: set_length('1);
                4: set_length('0);
                5: set_length(CFG_W'(1));
                6: set_length(CFG_W'(DEPTH));
                default: set_length(CFG_W'(($urandom_range(99) < 75) ? $urandom_range(40, 2)
                                                                     : $urandom_range(300, 41)));
            endcase
            if ($urandom_range(99) < 30) send_query();
            fill_loaded();
            build();
            ops = $urandom_range(60, 20);
            repeat (ops) begin
                pick = $urandom_range(99);
                if (pick < 68) begin
                    send_query();
                end else if (pick < 76) begin
                    send_stray_query();
                end else if (pick < 84) begin
                    write_elem(pick_index(), rand_value());
                    if ($urandom_range(1)) send_query();
                    build();
                end else if (pick < 88) begin
                    send_item(CMD_NONE, POS_W'($urandom), POS_W'($urandom), $urandom);
                end else if (pick < 92) begin
                    if (cur_len < DEPTH) begin
                        write_elem(POS_W'($urandom_range(DEPTH - 1, cur_len)), rand_value());
                    end
                    build();
                end else if (pick < 96) begin
                    wait_drained();
                end else begin
                    build();
                end
            end
            phase++;
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/srmq_pkg.sv
hw/rtl/sparse_table_range_minimum.sv
verif/range_min_checker.sv
verif/testbench.sv
